>>> hdl/tbs_pkg.sv
// Package for the token bucket shaper: item types, event codes and queue sizing.
// Depends on nothing; used by the channel interfaces and the top level.
package tbs_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam logic [15:0] BucketReset = 16'd10;

  typedef enum logic [2:0] {
    EV_DROP_OVERSIZE = 3'd0,
    EV_QUEUED        = 3'd1,
    EV_DROP_FULL     = 3'd2,
    EV_TOKEN_ADDED   = 3'd3,
    EV_TOKEN_DROPPED = 3'd4,
    EV_RELEASED      = 3'd5
  } event_kind_e;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } operation_e;

  // One input item.
  typedef struct packed {
    operation_e  operation;
    logic [15:0] tokens_needed;
    logic [13:0] service_time;
  } in_item_t;

  // One result item.
  typedef struct packed {
    event_kind_e event_kind;
    logic [15:0] packet_number;
    logic [15:0] packet_tokens;
    logic [13:0] packet_service;
    logic [15:0] token_number;
    logic [15:0] bucket_level;
    logic        last_result;
  } out_item_t;

  // One waiting packet in the queue memory.
  typedef struct packed {
    logic [15:0] number;
    logic [15:0] tokens;
    logic [13:0] service;
  } entry_t;

endpackage

>>> hdl/tbs_in_if.sv
// Valid/ready channel that carries input items into the shaper.
// Depends on tbs_pkg for the item type.
interface tbs_in_if;
  logic             valid;
  logic             ready;
  tbs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/tbs_out_if.sv
// Valid/ready channel that carries result items out of the shaper.
// Depends on tbs_pkg for the item type.
interface tbs_out_if;
  logic               valid;
  logic               ready;
  tbs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/token_bucket_shaper.sv
// Token bucket shaper with a waiting queue of packets.
// Depends on tbs_pkg, tbs_in_if and tbs_out_if.
//
// Usage: input items arrive on in_i (valid/ready); an item is either a packet
// arrival or a token tick. Each item gives one or more result items on out_o,
// the last of them flagged by last_result. bucket_size is written through
// cfg_we_i / cfg_wdata_i; the user must do so only while idle (not checked).
// Sequence: an item is taken and then checked in the next cycle. A dropped
// arrival goes from the check straight to the hand-off of its only result, a
// tick with an empty queue passes the read of the queue head on the way, and
// any other item also the fit check. Every further release of a queued packet
// repeats the memory read of the queue head, fit check against the bucket
// level and hand-off to the output register, all through a single shared
// subtract-and-compare unit. An arrival releases at most one queued packet, a
// token tick up to a full queue.
// Reset: the bucket is empty, the queue is empty, both counters are zero and
// bucket_size returns to 10. The queue memory itself is not cleared.
// Stalls: one result waits in the output register while the next is prepared;
// the sequencer holds until the receiver takes it. in_i.ready is high only
// while no item is in work.
module token_bucket_shaper (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  tbs_in_if.sink       in_i,
  tbs_out_if.source    out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FIT,
    ST_PUSH
  } state_e;

  state_e                    state_q;
  logic [15:0]               bucket_size_q;
  logic [15:0]               level_q;
  logic [tbs_pkg::PtrW-1:0]  head_q;
  logic [tbs_pkg::PtrW-1:0]  tail_q;
  logic [tbs_pkg::CntW-1:0]  count_q;
  logic [tbs_pkg::CntW-1:0]  rel_left_q;
  logic [15:0]               pkt_cnt_q;
  logic [15:0]               tok_cnt_q;
  tbs_pkg::in_item_t         item_q;
  tbs_pkg::out_item_t        pend_q;
  tbs_pkg::out_item_t        out_q;
  logic                      out_valid_q;
  logic                      fit_q;

  tbs_pkg::entry_t           queue_mem [tbs_pkg::QueueDepth];
  tbs_pkg::entry_t           rd_data_q;
  tbs_pkg::entry_t           wr_data;
  logic                      wr_en;

  logic [15:0]               alu_a;
  logic [15:0]               alu_b;
  logic [16:0]               alu_diff;
  logic                      alu_borrow;
  logic                      out_free;
  logic                      queue_full;

  // Next slot of a circular queue pointer.
  function automatic logic [tbs_pkg::PtrW-1:0] next_slot(
    input logic [tbs_pkg::PtrW-1:0] ptr
  );
    logic [tbs_pkg::PtrW-1:0] res;
    if (ptr == tbs_pkg::PtrW'(tbs_pkg::QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  // Shared subtract-and-compare unit; borrow means a < b.
  always_comb begin
    case (state_q)
      ST_CHECK: begin
        if (item_q.operation == tbs_pkg::OP_ARRIVAL) begin
          alu_a = bucket_size_q;
          alu_b = item_q.tokens_needed;
        end else begin
          alu_a = level_q;
          alu_b = bucket_size_q;
        end
      end
      default: begin
        alu_a = level_q;
        alu_b = rd_data_q.tokens;
      end
    endcase
    alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    alu_borrow = alu_diff[16];
  end

  assign queue_full = (count_q == tbs_pkg::CntW'(tbs_pkg::QueueDepth));
  assign out_free   = !out_valid_q || out_o.ready;

  // Enqueue of an accepted arrival.
  assign wr_en = (state_q == ST_CHECK) && (item_q.operation == tbs_pkg::OP_ARRIVAL) &&
                 !alu_borrow && !queue_full;
  assign wr_data = '{number: pkt_cnt_q, tokens: item_q.tokens_needed,
                     service: item_q.service_time};

  // Queue memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      queue_mem[tail_q] <= wr_data;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= queue_mem[head_q];
    end
  end

  // Sequencer, bucket state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      bucket_size_q <= tbs_pkg::BucketReset;
      level_q       <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      rel_left_q    <= '0;
      pkt_cnt_q     <= '0;
      tok_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
      fit_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bucket_size_q <= cfg_wdata_i;
      end
      // The hand-off state reloads the output register itself.
      if (out_valid_q && out_o.ready && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            item_q <= in_i.data;
            if (in_i.data.operation == tbs_pkg::OP_ARRIVAL) begin
              pkt_cnt_q <= pkt_cnt_q + 16'd1;
            end else begin
              tok_cnt_q <= tok_cnt_q + 16'd1;
            end
            state_q <= ST_CHECK;
          end
        end

        // First result of the item: drop, enqueue or token update.
        ST_CHECK: begin
          pend_q.token_number <= tok_cnt_q;
          fit_q               <= 1'b0;
          if (item_q.operation == tbs_pkg::OP_ARRIVAL) begin
            pend_q.packet_number  <= pkt_cnt_q;
            pend_q.packet_tokens  <= item_q.tokens_needed;
            pend_q.packet_service <= item_q.service_time;
            pend_q.bucket_level   <= level_q;
            if (alu_borrow) begin
              pend_q.event_kind  <= tbs_pkg::EV_DROP_OVERSIZE;
              pend_q.last_result <= 1'b1;
              state_q            <= ST_PUSH;
            end else if (queue_full) begin
              pend_q.event_kind  <= tbs_pkg::EV_DROP_FULL;
              pend_q.last_result <= 1'b1;
              state_q            <= ST_PUSH;
            end else begin
              pend_q.event_kind  <= tbs_pkg::EV_QUEUED;
              pend_q.last_result <= 1'b0;
              tail_q             <= next_slot(tail_q);
              count_q            <= count_q + 1'b1;
              rel_left_q         <= tbs_pkg::CntW'(1);
              state_q            <= ST_READ;
            end
          end else begin
            pend_q.packet_number  <= '0;
            pend_q.packet_tokens  <= '0;
            pend_q.packet_service <= '0;
            pend_q.last_result    <= 1'b0;
            if (alu_borrow) begin
              pend_q.event_kind   <= tbs_pkg::EV_TOKEN_ADDED;
              pend_q.bucket_level <= level_q + 16'd1;
              level_q             <= level_q + 16'd1;
            end else begin
              pend_q.event_kind   <= tbs_pkg::EV_TOKEN_DROPPED;
              pend_q.bucket_level <= level_q;
            end
            rel_left_q <= tbs_pkg::CntW'(tbs_pkg::QueueDepth);
            state_q    <= ST_READ;
          end
        end

        // Read the queue head; stop when no further release is possible.
        ST_READ: begin
          if (count_q == '0 || rel_left_q == '0) begin
            pend_q.last_result <= 1'b1;
            fit_q              <= 1'b0;
            state_q            <= ST_PUSH;
          end else begin
            state_q <= ST_FIT;
          end
        end

        // Does the head packet fit in the bucket?
        ST_FIT: begin
          fit_q              <= !alu_borrow;
          pend_q.last_result <= alu_borrow;
          state_q            <= ST_PUSH;
        end

        // Hand the pending result to the output register, then release the head if it fits.
        ST_PUSH: begin
          if (out_free) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            if (fit_q) begin
              pend_q.event_kind     <= tbs_pkg::EV_RELEASED;
              pend_q.packet_number  <= rd_data_q.number;
              pend_q.packet_tokens  <= rd_data_q.tokens;
              pend_q.packet_service <= rd_data_q.service;
              pend_q.token_number   <= tok_cnt_q;
              pend_q.bucket_level   <= alu_diff[15:0];
              pend_q.last_result    <= 1'b0;
              level_q               <= alu_diff[15:0];
              head_q                <= next_slot(head_q);
              count_q               <= count_q - 1'b1;
              rel_left_q            <= rel_left_q - 1'b1;
              state_q               <= ST_READ;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
